[design/pidh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidh_pkg
// Types and fixed constants shared by the heater PID / slow PWM controller.
// ----------------------------------------------------------------------------
package pidh_pkg;

	localparam int TEMP_W    = 16;
	localparam int ERR_W     = 17;
	localparam int DIFF_W    = 18;
	localparam int DUTY_W    = 10;
	localparam int WINDOW_W  = 11;
	localparam int UPDATE_W  = 17;
	localparam int GAIN_W    = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam int DUTY_RESET = 500;

	localparam logic [GAIN_W-1:0] GAIN_P_RESET        = 16'd1600;
	localparam logic [GAIN_W-1:0] GAIN_I_RESET        = 16'd16;
	localparam logic [GAIN_W-1:0] GAIN_D_RESET        = 16'd8000;
	localparam logic [TEMP_W-1:0] TARGET_TEMP_RESET   = 16'd0;
	localparam logic [15:0]       UPDATE_PERIOD_RESET = 16'd1000;

	typedef enum logic [1:0] {
		MODE_RUN   = 2'd0,
		MODE_PAUSE = 2'd1,
		MODE_STOP  = 2'd2,
		MODE_HOLD  = 2'd3
	} pidh_mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN_P        = 3'd0,
		REG_GAIN_I        = 3'd1,
		REG_GAIN_D        = 3'd2,
		REG_TARGET_TEMP   = 3'd3,
		REG_UPDATE_PERIOD = 3'd4
	} pidh_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0] gain_p;
		logic [GAIN_W-1:0] gain_i;
		logic [GAIN_W-1:0] gain_d;
		logic [TEMP_W-1:0] target_temp;
		logic [15:0]       update_period;
	} pidh_cfg_t;

endpackage : pidh_pkg
`default_nettype wire

[design/pidh_cfg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidh_cfg
// Configuration register file: gains, setpoint and update period.
// ----------------------------------------------------------------------------
module pidh_cfg
	import pidh_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output pidh_cfg_t                  cfg
);

	pidh_cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p        <= GAIN_P_RESET;
			cfg_q.gain_i        <= GAIN_I_RESET;
			cfg_q.gain_d        <= GAIN_D_RESET;
			cfg_q.target_temp   <= TARGET_TEMP_RESET;
			cfg_q.update_period <= UPDATE_PERIOD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_GAIN_P:        cfg_q.gain_p        <= cfg_data;
				REG_GAIN_I:        cfg_q.gain_i        <= cfg_data;
				REG_GAIN_D:        cfg_q.gain_d        <= cfg_data;
				REG_TARGET_TEMP:   cfg_q.target_temp   <= cfg_data;
				REG_UPDATE_PERIOD: cfg_q.update_period <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule : pidh_cfg
`default_nettype wire

[design/pidh_pwm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidh_pwm
// Slow time-proportioned PWM: window age and heater level for one tick.
// ----------------------------------------------------------------------------
module pidh_pwm
	import pidh_pkg::*;
#(
	parameter int DUTY_PERIOD = 1000
) (
	input  wire logic [WINDOW_W-1:0] window_age,
	input  wire logic                heater,
	input  wire logic [DUTY_W-1:0]   duty,
	output logic [WINDOW_W-1:0]      window_age_next,
	output logic                     heater_next
);

	localparam logic [WINDOW_W-1:0] PERIOD_W = WINDOW_W'(DUTY_PERIOD);

	logic [WINDOW_W-1:0] age_inc;

	always_comb begin
		age_inc = (&window_age) ? window_age : window_age + 1'b1;
		window_age_next = age_inc;
		heater_next = heater;
		if (age_inc > PERIOD_W) begin
			// an idle window keeps its level and lets the age saturate
			if (duty != '0) begin
				heater_next = 1'b1;
				window_age_next = '0;
			end
		end else if (age_inc > {1'b0, duty}) begin
			heater_next = 1'b0;
		end
	end

endmodule : pidh_pwm
`default_nettype wire

[design/pidh_pid.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pidh_pid
// One PID step: error, saturating integral, difference, weighted sum and
// clamp of the negated result to the PWM period.
// ----------------------------------------------------------------------------
module pidh_pid
	import pidh_pkg::*;
#(
	parameter int DUTY_PERIOD = 1000,
	parameter int SUM_WIDTH   = 24
) (
	input  wire logic signed [TEMP_W-1:0]    temp,
	input  wire pidh_cfg_t                   cfg,
	input  wire logic signed [ERR_W-1:0]     prior_error,
	input  wire logic signed [SUM_WIDTH-1:0] error_sum,
	output logic signed [ERR_W-1:0]          error_next,
	output logic signed [SUM_WIDTH-1:0]      sum_next,
	output logic [DUTY_W-1:0]                duty_next
);

	// the integral term is held to +-2^34, beyond the reach of the other two
	// terms, so the sign and the clamped duty come out as with any wider limit
	localparam int SN_W  = 35;
	localparam int TI_W  = 36;
	localparam int ACC_W = 37;
	localparam int EXT_W = 49;
	localparam logic signed [EXT_W-1:0] S_LIM  = 49'sd17179869184;
	localparam logic signed [51:0]      P_LIM  = 52'sd17179869184;
	localparam logic signed [TI_W-1:0]  TI_LIM = 36'sd17179869184;
	localparam logic [ACC_W-9:0]        PERIOD_Q = (ACC_W - 8)'(DUTY_PERIOD);

	logic signed [ERR_W-1:0]     e;
	logic signed [SUM_WIDTH:0]   sum_wide;
	logic signed [DIFF_W-1:0]    d;
	logic signed [33:0]          tp;
	logic signed [34:0]          td;
	logic signed [EXT_W-1:0]     s_ext;
	logic                        s_pos;
	logic                        s_neg;
	logic signed [SN_W-1:0]      s_n;
	logic signed [51:0]          prod;
	logic signed [TI_W-1:0]      ti;
	logic signed [ACC_W-1:0]     acc;
	logic [ACC_W-1:0]            neg;
	logic [ACC_W-9:0]            q;

	always_comb begin
		e = $signed({temp[TEMP_W-1], temp})
			- $signed({cfg.target_temp[TEMP_W-1], cfg.target_temp});

		sum_wide = $signed({error_sum[SUM_WIDTH-1], error_sum})
			+ $signed({{(SUM_WIDTH + 1 - ERR_W){e[ERR_W-1]}}, e});
		if (sum_wide[SUM_WIDTH] != sum_wide[SUM_WIDTH-1]) begin
			sum_next = sum_wide[SUM_WIDTH] ? {1'b1, {(SUM_WIDTH-1){1'b0}}}
				: {1'b0, {(SUM_WIDTH-1){1'b1}}};
		end else begin
			sum_next = sum_wide[SUM_WIDTH-1:0];
		end

		d = $signed({e[ERR_W-1], e}) - $signed({prior_error[ERR_W-1], prior_error});

		tp = $signed({1'b0, cfg.gain_p}) * e;
		td = $signed({1'b0, cfg.gain_d}) * d;

		s_ext = $signed({{(EXT_W - SUM_WIDTH){sum_next[SUM_WIDTH-1]}}, sum_next});
		s_pos = (s_ext >= S_LIM);
		s_neg = (s_ext <= -S_LIM);
		s_n = s_ext[SN_W-1:0];
		prod = $signed({1'b0, cfg.gain_i}) * s_n;

		priority if (cfg.gain_i == '0) begin
			ti = '0;
		end else if (s_pos || prod > P_LIM) begin
			ti = TI_LIM;
		end else if (s_neg || prod < -P_LIM) begin
			ti = -TI_LIM;
		end else begin
			ti = prod[TI_W-1:0];
		end

		acc = tp + td + ti;
		neg = -acc;
		q = neg[ACC_W-1:8];

		if (!acc[ACC_W-1]) begin
			duty_next = '0;
		end else if (q > PERIOD_Q) begin
			duty_next = PERIOD_Q[DUTY_W-1:0];
		end else begin
			duty_next = q[DUTY_W-1:0];
		end

		error_next = e;
	end

endmodule : pidh_pid
`default_nettype wire

[design/pid_heater_time_proportioned_pwm.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pid_heater_time_proportioned_pwm
// Heater controller: PID regulator driving a slow time-proportioned PWM.
// ----------------------------------------------------------------------------
// Each request is one millisecond tick carrying the measured temperature and
// a mode. The block takes one request every clock cycle unless in_stall is
// high: a request lands in the input register, from which the PWM, update
// timer and PID arithmetic (three parallel multiplies, a sum and a clamp)
// settle in one pass into the controller state, which doubles as the result
// register, so the result is offered once the input register has advanced
// into it. A stalled result holds the input register, and input stall rises
// only while both are full and the result is stalled.
// Configuration registers are always ready and take effect on the next tick.
// No memories, no startup sweep: the block is ready as soon as reset ends.
// ----------------------------------------------------------------------------
module pid_heater_time_proportioned_pwm
	import pidh_pkg::*;
#(
	parameter int DUTY_PERIOD = 1000,
	parameter int SUM_WIDTH   = 24
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic signed [TEMP_W-1:0] temp_now,
	input  wire logic [1:0]               run_mode,
	input  wire logic                     pause_regulates,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic                          heater_on,
	output logic                          motors_on,
	output logic [DUTY_W-1:0]             duty_now,
	input  wire logic                     cfg_valid,
	output logic                          cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

	localparam logic [DUTY_W-1:0] DUTY_INIT =
		(DUTY_RESET < DUTY_PERIOD) ? DUTY_W'(DUTY_RESET) : DUTY_W'(DUTY_PERIOD);

	pidh_cfg_t cfg;

	logic                     valid_s1;
	logic signed [TEMP_W-1:0] temp_s1;
	pidh_mode_t               mode_s1;
	logic                     regulate_s1;

	logic                        out_valid_q;
	logic [WINDOW_W-1:0]         window_age_q;
	logic [UPDATE_W-1:0]         update_age_q;
	logic                        heater_q;
	logic                        motor_q;
	logic signed [ERR_W-1:0]     prior_error_q;
	logic signed [SUM_WIDTH-1:0] error_sum_q;
	logic [DUTY_W-1:0]           duty_q;

	logic                        advance;
	logic [WINDOW_W-1:0]         window_age_n;
	logic                        heater_n;
	logic [UPDATE_W-1:0]         update_inc;
	logic [UPDATE_W-1:0]         update_age_n;
	logic                        motor_n;
	logic signed [ERR_W-1:0]     prior_error_n;
	logic signed [SUM_WIDTH-1:0] error_sum_n;
	logic [DUTY_W-1:0]           duty_n;
	logic signed [ERR_W-1:0]     pid_error;
	logic signed [SUM_WIDTH-1:0] pid_sum;
	logic [DUTY_W-1:0]           pid_duty;

	pidh_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pidh_pwm #(
		.DUTY_PERIOD (DUTY_PERIOD)
	) u_pwm (
		.window_age      (window_age_q),
		.heater          (heater_q),
		.duty            (duty_q),
		.window_age_next (window_age_n),
		.heater_next     (heater_n)
	);

	pidh_pid #(
		.DUTY_PERIOD (DUTY_PERIOD),
		.SUM_WIDTH   (SUM_WIDTH)
	) u_pid (
		.temp        (temp_s1),
		.cfg         (cfg),
		.prior_error (prior_error_q),
		.error_sum   (error_sum_q),
		.error_next  (pid_error),
		.sum_next    (pid_sum),
		.duty_next   (pid_duty)
	);

	// the state registers are the result: they change only when the
	// previous result has been taken or is taken now
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	assign out_valid = out_valid_q;
	assign heater_on = heater_q;
	assign motors_on = motor_q;
	assign duty_now  = duty_q;

	always_comb begin
		update_inc    = (&update_age_q) ? update_age_q : update_age_q + 1'b1;
		update_age_n  = update_inc;
		motor_n       = motor_q;
		prior_error_n = prior_error_q;
		error_sum_n   = error_sum_q;
		duty_n        = duty_q;
		if (update_inc > {1'b0, cfg.update_period}) begin
			update_age_n = '0;
			unique case (mode_s1)
				MODE_RUN: begin
					motor_n       = 1'b1;
					prior_error_n = pid_error;
					error_sum_n   = pid_sum;
					duty_n        = pid_duty;
				end
				MODE_PAUSE: begin
					if (regulate_s1) begin
						prior_error_n = pid_error;
						error_sum_n   = pid_sum;
						duty_n        = pid_duty;
					end else begin
						prior_error_n = '0;
						error_sum_n   = '0;
						duty_n        = '0;
					end
				end
				MODE_STOP: begin
					motor_n       = 1'b0;
					prior_error_n = '0;
					error_sum_n   = '0;
					duty_n        = '0;
				end
				MODE_HOLD: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			temp_s1     <= temp_now;
			mode_s1     <= pidh_mode_t'(run_mode);
			regulate_s1 <= pause_regulates;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q   <= 1'b0;
			window_age_q  <= '0;
			update_age_q  <= '0;
			heater_q      <= 1'b0;
			motor_q       <= 1'b0;
			prior_error_q <= '0;
			error_sum_q   <= '0;
			duty_q        <= DUTY_INIT;
		end else begin
			if (advance) begin
				out_valid_q   <= 1'b1;
				window_age_q  <= window_age_n;
				update_age_q  <= update_age_n;
				heater_q      <= heater_n;
				motor_q       <= motor_n;
				prior_error_q <= prior_error_n;
				error_sum_q   <= error_sum_n;
				duty_q        <= duty_n;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule : pid_heater_time_proportioned_pwm
`default_nettype wire
